// ===== rtl/core/kfc_pkg.sv =====
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared constants, types and address helpers for the k-mer frequency counter.
// ----------------------------------------------------------------------------
package kfc_pkg;

   localparam int MAX_K       = 6;
   localparam int COUNT_BITS  = 32;
   localparam int CODE_BITS   = 2 * MAX_K;
   localparam int STORE_DEPTH = ((1 << (2 * MAX_K + 2)) - 4) / 3;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int K_BITS      = $clog2(MAX_K + 2);
   localparam int LEN_BITS    = 3;
   localparam int WORD_BITS   = 32;

   localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = 3'd2;

   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_G       = 8'h47;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_Z       = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam logic ACTION_FEED = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic upd_read;
      logic upd_write;
      logic lookup;
      logic load;
   } kfc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic upd_done;
      logic is_read;
      logic out_free;
   } kfc_status_type;

   typedef logic [2**K_BITS-1:0][ADDR_BITS-1:0] base_table_type;

   // first store entry of each bank, bank k holds the 4^k words of length k
   function automatic base_table_type base_table_f();
      base_table_type t;
      longint acc;
      longint pw;
      t   = '0;
      acc = 0;
      pw  = 4;
      for (int j = 1; j < 2**K_BITS; j++) begin
         t[j] = ADDR_BITS'(acc);
         acc  = acc + pw;
         pw   = pw * 4;
      end
      return t;
   endfunction

   localparam base_table_type BANK_BASE = base_table_f();

   function automatic logic [ADDR_BITS-1:0] addr_f(logic [K_BITS-1:0] k,
                                                   logic [CODE_BITS-1:0] code);
      logic [CODE_BITS-1:0] mask;
      for (int i = 0; i < CODE_BITS; i++) begin
         mask[i] = (i < 2 * int'(k));
      end
      return BANK_BASE[k] + ADDR_BITS'(code & mask);
   endfunction

endpackage

// ===== rtl/core/kfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kfc_ctrl
// Sequencer: clearing pass, per-length counter updates and counter reads.
// ----------------------------------------------------------------------------
module kfc_ctrl import kfc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  kfc_status_type status,
   output kfc_cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_UPD_RD = 3'd2;
   localparam logic [2:0] ST_UPD_WR = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;
   localparam logic [2:0] ST_LOAD   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.is_read ? ST_LOOKUP : ST_UPD_RD;
            end
         end
         ST_UPD_RD: begin
            if (status.upd_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.upd_read = 1'b1;
               state_in     = ST_UPD_WR;
            end
         end
         ST_UPD_WR: begin
            cmd.upd_write = 1'b1;
            state_in      = ST_UPD_RD;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/kfc_datapath.sv =====
// ----------------------------------------------------------------------------
// kfc_datapath
// Text decoding, rolling word, counter store and result register.
// ----------------------------------------------------------------------------
module kfc_datapath import kfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  kfc_cmd_type           cmd,
   output kfc_status_type        status,
   input  logic                  req_action,
   input  logic [7:0]            req_text_byte,
   input  logic [2:0]            req_read_length,
   input  logic [11:0]           req_read_index,
   input  logic                  csr_write,
   input  logic [LEN_BITS-1:0]   csr_max_word_length,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_BITS-1:0]  rsp_word_count
);

   logic [COUNT_BITS-1:0] mem [STORE_DEPTH];

   logic [LEN_BITS-1:0]   max_len_ff, max_len_in;
   logic                  in_header_ff, in_header_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [K_BITS-1:0]     run_ff, run_in;
   logic [K_BITS-1:0]     lim_ff, lim_in;
   logic [K_BITS-1:0]     k_ff, k_in;
   logic [ADDR_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [ADDR_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [COUNT_BITS-1:0] mem_q_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  rsp_word_ff, rsp_word_in;

   logic [7:0]            upper;
   logic                  is_letter;
   logic                  is_base;
   logic [1:0]            base_code;
   logic [K_BITS-1:0]     run_next;
   logic [K_BITS-1:0]     eff_max;
   logic [ADDR_BITS-1:0]  upd_addr;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic                  mem_we;
   logic                  mem_re;
   logic [COUNT_BITS-1:0] mem_wdata;

   // byte decode
   always_comb begin
      upper = req_text_byte;
      if (req_text_byte >= CHAR_LOWER_A && req_text_byte <= CHAR_LOWER_Z) begin
         upper = req_text_byte - CASE_OFFSET;
      end
      is_letter = (upper >= CHAR_A) && (upper <= CHAR_Z);
      is_base   = 1'b1;
      base_code = BASE_A;
      case (upper)
         CHAR_A:  base_code = BASE_A;
         CHAR_C:  base_code = BASE_C;
         CHAR_G:  base_code = BASE_G;
         CHAR_T:  base_code = BASE_T;
         default: is_base = 1'b0;
      endcase
      run_next = (int'(run_ff) < MAX_K) ? run_ff + 1'b1 : run_ff;
      if (max_len_ff == '0) begin
         eff_max = K_BITS'(1);
      end else if (int'(max_len_ff) > MAX_K) begin
         eff_max = K_BITS'(MAX_K);
      end else begin
         eff_max = K_BITS'(max_len_ff);
      end
   end

   always_comb begin
      max_len_in   = csr_write ? csr_max_word_length : max_len_ff;
      in_header_in = in_header_ff;
      code_in      = code_ff;
      run_in       = run_ff;
      lim_in       = lim_ff;
      k_in         = k_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;
      if (cmd.accept) begin
         k_in   = K_BITS'(1);
         lim_in = '0;
         if (req_action == ACTION_READ) begin
            rd_addr_in = addr_f(K_BITS'(req_read_length), CODE_BITS'(req_read_index));
            rd_ok_in   = (req_read_length != '0) && (int'(req_read_length) <= MAX_K);
         end else if (in_header_ff) begin
            if (req_text_byte == CHAR_LF) begin
               in_header_in = 1'b0;
            end
         end else if (req_text_byte == CHAR_GT) begin
            in_header_in = 1'b1;
            code_in      = '0;
            run_in       = '0;
         end else if (is_letter) begin
            if (is_base) begin
               code_in = CODE_BITS'({code_ff, base_code});
               run_in  = run_next;
               lim_in  = (eff_max < run_next) ? eff_max : run_next;
            end else begin
               code_in = '0;
               run_in  = '0;
            end
         end
      end
      if (cmd.upd_write) begin
         k_in = k_ff + 1'b1;
      end
   end

   // counter store access
   always_comb begin
      upd_addr  = addr_f(k_ff, code_ff);
      mem_addr  = cmd.clear_step ? clr_addr_ff : (cmd.lookup ? rd_addr_ff : upd_addr);
      mem_we    = cmd.clear_step | cmd.upd_write;
      mem_re    = cmd.lookup | cmd.upd_read;
      mem_wdata = '0;
      if (cmd.upd_write) begin
         mem_wdata = (&mem_q_ff) ? mem_q_ff : mem_q_ff + 1'b1;
      end
      clr_addr_in = cmd.clear_step ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rd_ok_ff ? WORD_BITS'(mem_q_ff) : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         in_header_ff <= 1'b0;
         code_ff      <= '0;
         run_ff       <= '0;
         lim_ff       <= '0;
         k_ff         <= '0;
         rd_ok_ff     <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         in_header_ff <= in_header_in;
         code_ff      <= code_in;
         run_ff       <= run_in;
         lim_ff       <= lim_in;
         k_ff         <= k_in;
         rd_ok_ff     <= rd_ok_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.clear_last = (clr_addr_ff == ADDR_BITS'(STORE_DEPTH - 1));
   assign status.upd_done   = (k_ff > lim_ff);
   assign status.is_read    = (req_action == ACTION_READ);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_count = rsp_word_ff;

endmodule

// ===== rtl/core/kmer_frequency_counter_core.sv =====
// ----------------------------------------------------------------------------
// kmer_frequency_counter_core
// FASTA text in, k-mer histogram counters for lengths 1 to 6, counter reads out.
// ----------------------------------------------------------------------------
// read item: store lookup, then load into the result register once it is free
// feed item: n lengths updated, one store read-modify-write each
// throughput set by the single-port counter store, one access per cycle
// reset: synchronous, then a clearing pass over all 5460 store entries with req_stall high
// csr writes are taken at any time, including during the clearing pass
module kmer_frequency_counter_core import kfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [7:0]           req_text_byte,
   input  logic [2:0]           req_read_length,
   input  logic [11:0]          req_read_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_word_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEN_BITS-1:0]  csr_max_word_length
);

   kfc_cmd_type    cmd;
   kfc_status_type status;

   assign csr_ready = 1'b1;

   kfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kfc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_text_byte       (req_text_byte),
      .req_read_length     (req_read_length),
      .req_read_index      (req_read_index),
      .csr_write           (csr_valid & csr_ready),
      .csr_max_word_length (csr_max_word_length),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_word_count      (rsp_word_count)
   );

endmodule

// ===== rtl/core/kfc_checker.sv =====
// ----------------------------------------------------------------------------
// kfc_checker
// Port-level checks on the k-mer frequency counter, bound to the top level.
// ----------------------------------------------------------------------------
module kfc_checker import kfc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_action,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WORD_BITS-1:0] rsp_word_count
);

   // clearing pass holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("item window open right after reset");

   // one item at a time
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken back to back");

   // a read holds the input for its lookup and load
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACTION_READ |=> req_stall ##1 req_stall)
      else $error("read item finished too early");

   // a result appears only while an item is in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_count))
      else $error("stalled result changed");

endmodule

bind kmer_frequency_counter_core kfc_checker u_kfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_action     (req_action),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_word_count (rsp_word_count)
);
